>>> hw/rtl/i2cms_pkg.sv
package i2cms_pkg;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_STOP  = 3'd1;
    localparam logic [2:0] K_WRITE = 3'd2;
    localparam logic [2:0] K_READ  = 3'd3;
    localparam logic [2:0] K_PROBE = 3'd4;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST0  = 5'd1;
    localparam logic [4:0] PH_ST1  = 5'd2;
    localparam logic [4:0] PH_ST2  = 5'd3;
    localparam logic [4:0] PH_SP0  = 5'd4;
    localparam logic [4:0] PH_SP1  = 5'd5;
    localparam logic [4:0] PH_SP2  = 5'd6;
    localparam logic [4:0] PH_WD   = 5'd7;
    localparam logic [4:0] PH_WC   = 5'd8;
    localparam logic [4:0] PH_AK0  = 5'd9;
    localparam logic [4:0] PH_AK1  = 5'd10;
    localparam logic [4:0] PH_AKP  = 5'd11;
    localparam logic [4:0] PH_AKS1 = 5'd12;
    localparam logic [4:0] PH_AKS2 = 5'd13;
    localparam logic [4:0] PH_AKE  = 5'd14;
    localparam logic [4:0] PH_RH   = 5'd15;
    localparam logic [4:0] PH_RL   = 5'd16;
    localparam logic [4:0] PH_RA0  = 5'd17;
    localparam logic [4:0] PH_RA1  = 5'd18;
    localparam logic [4:0] PH_RA2  = 5'd19;
    localparam logic [4:0] PH_RA3  = 5'd20;

    localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] kind;
        logic [7:0] write_byte;
        logic       ack_after_read;
        logic       sda_sample;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_ack;
    } result_t;

    typedef struct packed {
        logic [4:0] phase;
        logic [2:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] poll_count;
        logic [2:0] current_kind;
        logic       send_ack;
        logic       pin_scl;
        logic       pin_sda;
        logic [7:0] last_read;
        logic       nak_flag;
    } state_t;

endpackage

>>> hw/rtl/i2c_master_bit_sequencer_top.sv
// Path: an input transfer passes through one input register and then one result
// register before its result can transfer.
// Throughput: one slot per cycle while m_tready does not hold back a pending result.
// Reset: aresetn is synchronous and active low. It returns the sequencer to
// idle with both pins released, clears read data and the no-ack flag, empties
// both registers and sets the timeout register to 250.
module i2c_master_bit_sequencer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd_valid [0], write_byte [8:1], ack_after_read [9], sda_sample [10], zero fill.
    input  logic [15:0] s_tdata,
    // kind [2:0].
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // scl_level [0], sda_level [1], busy_res [2], done_res [3], read_data [11:4],
    // no_ack [12], zero fill.
    output logic [15:0] m_tdata
);

    logic [7:0]          ack_timeout_reg;
    logic                in_valid_reg;
    i2cms_pkg::item_t    in_item_reg;
    logic                out_valid_reg;
    i2cms_pkg::result_t  out_res_reg;
    i2cms_pkg::state_t   st_reg;
    i2cms_pkg::state_t   st_next;
    i2cms_pkg::result_t  res_next;
    i2cms_pkg::item_t    s_item;
    logic                advance;

    assign s_item.cmd_valid      = s_tdata[0];
    assign s_item.kind           = s_tuser;
    assign s_item.write_byte     = s_tdata[8:1];
    assign s_item.ack_after_read = s_tdata[9];
    assign s_item.sda_sample     = s_tdata[10];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    i2cms_step u_step (
        .state_i       (st_reg),
        .item_i        (in_item_reg),
        .ack_timeout_i (ack_timeout_reg),
        .state_o       (st_next),
        .result_o      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= i2cms_pkg::ACK_TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            ack_timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{phase: i2cms_pkg::PH_IDLE, bit_count: 3'd0, shift_byte: 8'd0,
                        poll_count: 8'd0, current_kind: 3'd0, send_ack: 1'b0,
                        pin_scl: 1'b1, pin_sda: 1'b1, last_read: 8'd0,
                        nak_flag: 1'b0};
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_res_reg.no_ack, out_res_reg.read_data,
                       out_res_reg.done_res, out_res_reg.busy_res,
                       out_res_reg.sda_level, out_res_reg.scl_level};

    a_poll_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.phase == i2cms_pkg::PH_AKP |-> st_reg.poll_count <= ack_timeout_reg)
        else $error("Acknowledge poll count ran past the timeout.");

    a_bit_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg.phase != i2cms_pkg::PH_WD && st_reg.phase != i2cms_pkg::PH_WC &&
         st_reg.phase != i2cms_pkg::PH_RH && st_reg.phase != i2cms_pkg::PH_RL)
        |-> st_reg.bit_count == 3'd0)
        else $error("Bit counter is nonzero outside a data bit phase.");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.done_res |-> out_res_reg.busy_res)
        else $error("Done is flagged in a slot that is not busy.");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(st_reg))
        else $error("Sequencer state moved without a transfer.");

endmodule

>>> hw/rtl/i2cms_step.sv
module i2cms_step (
    input  i2cms_pkg::state_t  state_i,
    input  i2cms_pkg::item_t   item_i,
    input  logic [7:0]         ack_timeout_i,
    output i2cms_pkg::state_t  state_o,
    output i2cms_pkg::result_t result_o
);

    i2cms_pkg::state_t s;
    logic              busy;
    logic              done;
    logic [8:0]        poll_inc;

    always_comb begin
        s        = state_i;
        busy     = 1'b0;
        done     = 1'b0;
        poll_inc = {1'b0, state_i.poll_count} + 9'd1;

        if (s.phase == i2cms_pkg::PH_IDLE && item_i.cmd_valid &&
            item_i.kind <= i2cms_pkg::K_PROBE) begin
            s.current_kind = item_i.kind;
            s.bit_count    = 3'd0;
            s.poll_count   = 8'd0;
            case (item_i.kind)
                i2cms_pkg::K_START: s.phase = i2cms_pkg::PH_ST0;
                i2cms_pkg::K_PROBE: s.phase = i2cms_pkg::PH_ST0;
                i2cms_pkg::K_STOP:  s.phase = i2cms_pkg::PH_SP0;
                i2cms_pkg::K_WRITE: s.phase = i2cms_pkg::PH_WD;
                default:            s.phase = i2cms_pkg::PH_RH;
            endcase
            if (item_i.kind == i2cms_pkg::K_WRITE || item_i.kind == i2cms_pkg::K_PROBE) begin
                s.shift_byte = item_i.write_byte;
                s.nak_flag   = 1'b0;
            end else if (item_i.kind == i2cms_pkg::K_READ) begin
                s.shift_byte = 8'd0;
                s.send_ack   = item_i.ack_after_read;
            end
        end

        if (s.phase != i2cms_pkg::PH_IDLE) begin
            busy = 1'b1;
            case (s.phase)
                i2cms_pkg::PH_ST0: begin
                    s.pin_sda = 1'b1;
                    s.pin_scl = 1'b1;
                    s.phase   = i2cms_pkg::PH_ST1;
                end
                i2cms_pkg::PH_ST1: begin
                    s.pin_sda = 1'b0;
                    s.phase   = i2cms_pkg::PH_ST2;
                end
                i2cms_pkg::PH_ST2: begin
                    s.pin_scl = 1'b0;
                    if (s.current_kind == i2cms_pkg::K_PROBE) begin
                        s.phase = i2cms_pkg::PH_WD;
                    end else begin
                        s.phase = i2cms_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                end
                i2cms_pkg::PH_SP0: begin
                    s.pin_sda = 1'b0;
                    s.phase   = i2cms_pkg::PH_SP1;
                end
                i2cms_pkg::PH_SP1: begin
                    s.pin_scl = 1'b1;
                    s.phase   = i2cms_pkg::PH_SP2;
                end
                i2cms_pkg::PH_SP2: begin
                    s.pin_sda = 1'b1;
                    s.phase   = i2cms_pkg::PH_IDLE;
                    done      = 1'b1;
                end
                i2cms_pkg::PH_WD: begin
                    if (s.bit_count != 3'd0) begin
                        s.pin_scl = 1'b0;
                    end
                    s.pin_sda = s.shift_byte[7];
                    s.phase   = i2cms_pkg::PH_WC;
                end
                i2cms_pkg::PH_WC: begin
                    s.pin_scl    = 1'b1;
                    s.shift_byte = {s.shift_byte[6:0], 1'b0};
                    if (s.bit_count == 3'd7) begin
                        s.bit_count = 3'd0;
                        s.phase     = i2cms_pkg::PH_AK0;
                    end else begin
                        s.bit_count = s.bit_count + 3'd1;
                        s.phase     = i2cms_pkg::PH_WD;
                    end
                end
                i2cms_pkg::PH_AK0: begin
                    s.pin_scl    = 1'b0;
                    s.pin_sda    = 1'b1;
                    s.poll_count = 8'd0;
                    s.phase      = i2cms_pkg::PH_AK1;
                end
                i2cms_pkg::PH_AK1: begin
                    s.pin_scl = 1'b1;
                    s.phase   = i2cms_pkg::PH_AKP;
                end
                i2cms_pkg::PH_AKP: begin
                    if (!item_i.sda_sample) begin
                        s.pin_scl = 1'b0;
                        if (s.current_kind == i2cms_pkg::K_PROBE) begin
                            s.phase = i2cms_pkg::PH_SP0;
                        end else begin
                            s.phase = i2cms_pkg::PH_IDLE;
                            done    = 1'b1;
                        end
                    end else if (poll_inc > {1'b0, ack_timeout_i}) begin
                        s.pin_sda  = 1'b0;
                        s.nak_flag = 1'b1;
                        s.phase    = i2cms_pkg::PH_AKS1;
                    end else begin
                        s.poll_count = poll_inc[7:0];
                    end
                end
                i2cms_pkg::PH_AKS1: begin
                    s.pin_scl = 1'b1;
                    s.phase   = i2cms_pkg::PH_AKS2;
                end
                i2cms_pkg::PH_AKS2: begin
                    s.pin_sda = 1'b1;
                    s.phase   = i2cms_pkg::PH_AKE;
                end
                i2cms_pkg::PH_AKE: begin
                    s.pin_scl = 1'b0;
                    if (s.current_kind == i2cms_pkg::K_PROBE) begin
                        s.phase = i2cms_pkg::PH_SP0;
                    end else begin
                        s.phase = i2cms_pkg::PH_IDLE;
                        done    = 1'b1;
                    end
                end
                i2cms_pkg::PH_RH: begin
                    s.pin_scl    = 1'b1;
                    s.shift_byte = {s.shift_byte[6:0], item_i.sda_sample};
                    s.phase      = i2cms_pkg::PH_RL;
                end
                i2cms_pkg::PH_RL: begin
                    s.pin_scl = 1'b0;
                    if (s.bit_count == 3'd7) begin
                        s.bit_count = 3'd0;
                        s.phase     = i2cms_pkg::PH_RA0;
                    end else begin
                        s.bit_count = s.bit_count + 3'd1;
                        s.phase     = i2cms_pkg::PH_RH;
                    end
                end
                i2cms_pkg::PH_RA0: begin
                    s.pin_sda = ~s.send_ack;
                    s.phase   = i2cms_pkg::PH_RA1;
                end
                i2cms_pkg::PH_RA1: begin
                    s.pin_scl = 1'b1;
                    s.phase   = i2cms_pkg::PH_RA2;
                end
                i2cms_pkg::PH_RA2: begin
                    s.pin_scl = 1'b0;
                    if (s.send_ack) begin
                        s.phase = i2cms_pkg::PH_RA3;
                    end else begin
                        s.last_read = s.shift_byte;
                        s.phase     = i2cms_pkg::PH_IDLE;
                        done        = 1'b1;
                    end
                end
                i2cms_pkg::PH_RA3: begin
                    s.pin_sda   = 1'b1;
                    s.last_read = s.shift_byte;
                    s.phase     = i2cms_pkg::PH_IDLE;
                    done        = 1'b1;
                end
                default: begin
                    s.phase = i2cms_pkg::PH_IDLE;
                    busy    = 1'b0;
                end
            endcase
        end
    end

    assign state_o            = s;
    assign result_o.scl_level = s.pin_scl;
    assign result_o.sda_level = s.pin_sda;
    assign result_o.busy_res  = busy;
    assign result_o.done_res  = done;
    assign result_o.read_data = s.last_read;
    assign result_o.no_ack    = s.nak_flag;

endmodule
